// ===== design/char_lcd_write_sequencer_macros.svh =====
// Assertion macros shared by the character LCD write sequencer RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define CLCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define CLCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CLCD_ASSERT(lbl, prop, msg)
`define CLCD_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== design/clcd_pkg.sv =====
// Shared types, timing constants and the power-up command list of the LCD sequencer.
// No dependencies; used by every module of the block.
`default_nettype none
package clcd_pkg;

	localparam int COUNT_WIDTH = 15;
	localparam int LINE_LENGTH = 40;

	localparam logic [COUNT_WIDTH-1:0] DLY_POWER = COUNT_WIDTH'(20000);
	localparam logic [COUNT_WIDTH-1:0] DLY_SETUP = COUNT_WIDTH'(10);
	localparam logic [COUNT_WIDTH-1:0] DLY_HOLD  = COUNT_WIDTH'(5);
	localparam logic [COUNT_WIDTH-1:0] DLY_LATCH = COUNT_WIDTH'(10);
	localparam logic [COUNT_WIDTH-1:0] DLY_GAP   = COUNT_WIDTH'(20);

	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_INSTR  = 3'd1;
	localparam logic [2:0] CMD_DATA   = 3'd2;
	localparam logic [2:0] CMD_CURSOR = 3'd3;
	localparam logic [2:0] CMD_INIT   = 3'd4;

	localparam logic [7:0] BASE_LINE0 = 8'h80;
	localparam logic [7:0] BASE_LINE1 = 8'hC0;
	localparam logic [5:0] COL_MAX    = 6'(LINE_LENGTH - 1);

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_PAIR,
		KIND_NIBBLE
	} kind_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] byte_value;
		logic       row;
		logic [5:0] column;
	} item_t;

	typedef struct packed {
		logic       rs;
		logic       rw;
		logic       en;
		logic [7:0] bus;
		logic       busy;
		logic       rejected;
		logic       done;
	} result_t;

	typedef struct packed {
		logic                   present;
		logic [7:0]             value;
		kind_t                  kind;
		logic [COUNT_WIDTH-1:0] gap_us;
	} init_entry_t;

	// Power-up command list; mode4 picks the nibble-bus list
	function automatic init_entry_t init_entry(logic mode4, logic [3:0] idx);
		init_entry_t e;
		e = '{present: 1'b0, value: 8'h00, kind: KIND_BYTE, gap_us: '0};
		if (mode4) begin
			case (idx)
				4'd0: e = '{1'b1, 8'h30, KIND_NIBBLE, COUNT_WIDTH'(10000)};
				4'd1: e = '{1'b1, 8'h30, KIND_NIBBLE, COUNT_WIDTH'(1000)};
				4'd2: e = '{1'b1, 8'h30, KIND_NIBBLE, COUNT_WIDTH'(1000)};
				4'd3: e = '{1'b1, 8'h20, KIND_NIBBLE, COUNT_WIDTH'(0)};
				4'd4: e = '{1'b1, 8'h2C, KIND_PAIR, COUNT_WIDTH'(5000)};
				4'd5: e = '{1'b1, 8'h0C, KIND_PAIR, COUNT_WIDTH'(5000)};
				4'd6: e = '{1'b1, 8'h01, KIND_PAIR, COUNT_WIDTH'(5000)};
				4'd7: e = '{1'b1, 8'h02, KIND_PAIR, COUNT_WIDTH'(5000)};
				default: e.present = 1'b0;
			endcase
		end else begin
			case (idx)
				4'd0: e = '{1'b1, 8'h3C, KIND_BYTE, COUNT_WIDTH'(5000)};
				4'd1: e = '{1'b1, 8'h0F, KIND_BYTE, COUNT_WIDTH'(5000)};
				4'd2: e = '{1'b1, 8'h01, KIND_BYTE, COUNT_WIDTH'(5000)};
				4'd3: e = '{1'b1, 8'h02, KIND_BYTE, COUNT_WIDTH'(5000)};
				default: e.present = 1'b0;
			endcase
		end
		return e;
	endfunction

endpackage
`default_nettype wire

// ===== design/clcd_in_reg.sv =====
// Input register of the LCD sequencer: holds one accepted tick word.
// Depends on clcd_pkg for the item type.
`default_nettype none
module clcd_in_reg (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  clcd_pkg::item_t   item,
	input  wire               take,
	output logic              valid_s1,
	output clcd_pkg::item_t   item_s1
);
	import clcd_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item;
		end
	end

endmodule
`default_nettype wire

// ===== design/clcd_seq.sv =====
// Pin sequencer of the LCD block: one tick word per step, state doubles as result register.
// Depends on clcd_pkg and the assertion macros header.
`default_nettype none
`include "char_lcd_write_sequencer_macros.svh"
module clcd_seq (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                valid_s1,
	input  clcd_pkg::item_t    item_s1,
	input  wire                cfg_mode,
	output logic               take,
	output logic               out_valid,
	input  wire                out_ready,
	output clcd_pkg::result_t  res
);
	import clcd_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAIT,
		PH_SETUP,
		PH_HOLD1,
		PH_LATCH1,
		PH_GAP,
		PH_HOLD2,
		PH_LATCH2
	} phase_t;

	phase_t                 ph_q, ph_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_dec, gap_w;
	logic [3:0]             idx_q, idx_d;
	logic [7:0]             held_q, held_d, bus_q, bus_d, cursor_byte;
	logic                   rs_q, rs_d, en_q, en_d;
	logic                   mode_q, mode_d, init_q, init_d;
	kind_t                  kind_q, kind_d, req_kind;
	logic                   rej_q, rej_d, done_q, done_d;
	logic                   out_valid_q;
	logic                   is_req, end_wr, launch, finish;
	init_entry_t            ent_cur, ent_nxt, ent_sel;
	logic [5:0]             col_sat;

	assign take      = valid_s1 && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	assign is_req  = (item_s1.command == CMD_INSTR) || (item_s1.command == CMD_DATA) ||
	                 (item_s1.command == CMD_CURSOR) || (item_s1.command == CMD_INIT);
	assign ent_cur = init_entry(mode_q, idx_q);
	assign ent_nxt = init_entry(mode_q, idx_q + 4'd1);
	assign col_sat = (item_s1.column > COL_MAX) ? COL_MAX : item_s1.column;
	assign cursor_byte = (item_s1.row ? BASE_LINE1 : BASE_LINE0) + {2'b00, col_sat};
	assign req_kind = cfg_mode ? KIND_PAIR : KIND_BYTE;
	assign cnt_dec  = (cnt_q != '0) ? cnt_q - COUNT_WIDTH'(1) : cnt_q;
	assign gap_w    = ent_cur.present ? ent_cur.gap_us : '0;

	always_comb begin
		ph_d    = ph_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		held_d  = held_q;
		bus_d   = bus_q;
		rs_d    = rs_q;
		en_d    = en_q;
		mode_d  = mode_q;
		init_d  = init_q;
		kind_d  = kind_q;
		rej_d   = 1'b0;
		done_d  = 1'b0;
		end_wr  = 1'b0;
		launch  = 1'b0;
		finish  = 1'b0;
		ent_sel = ent_cur;

		if (is_req && ph_q == PH_IDLE) begin
			mode_d = cfg_mode;
			case (item_s1.command)
				CMD_INIT: begin
					init_d = 1'b1;
					idx_d  = '0;
					ph_d   = PH_WAIT;
					cnt_d  = DLY_POWER;
				end
				default: begin
					kind_d = req_kind;
					rs_d   = (item_s1.command == CMD_DATA);
					held_d = (item_s1.command == CMD_CURSOR) ? cursor_byte : item_s1.byte_value;
					ph_d   = PH_SETUP;
					cnt_d  = DLY_SETUP;
				end
			endcase
		end else if (ph_q != PH_IDLE) begin
			rej_d = is_req;
			cnt_d = cnt_dec;
			if (cnt_dec == '0) begin
				unique case (ph_q)
					PH_WAIT: launch = 1'b1;
					PH_SETUP: begin
						en_d  = 1'b1;
						ph_d  = PH_HOLD1;
						cnt_d = DLY_HOLD;
					end
					PH_HOLD1: begin
						bus_d = (kind_q == KIND_BYTE) ? held_q : {held_q[7:4], bus_q[3:0]};
						ph_d  = PH_LATCH1;
						cnt_d = DLY_LATCH;
					end
					PH_LATCH1: begin
						en_d = 1'b0;
						if (kind_q == KIND_PAIR) begin
							ph_d  = PH_GAP;
							cnt_d = DLY_GAP;
						end else begin
							end_wr = 1'b1;
						end
					end
					PH_GAP: begin
						en_d  = 1'b1;
						ph_d  = PH_HOLD2;
						cnt_d = DLY_HOLD;
					end
					PH_HOLD2: begin
						bus_d = {held_q[3:0], bus_q[3:0]};
						ph_d  = PH_LATCH2;
						cnt_d = DLY_LATCH;
					end
					PH_LATCH2: begin
						en_d   = 1'b0;
						end_wr = 1'b1;
					end
					default: ph_d = PH_IDLE;
				endcase
			end
		end

		// end of one write: next init step, init gap, or done
		if (end_wr) begin
			if (init_q) begin
				idx_d = idx_q + 4'd1;
				if (gap_w != '0) begin
					ph_d  = PH_WAIT;
					cnt_d = gap_w;
				end else begin
					launch  = 1'b1;
					ent_sel = ent_nxt;
				end
			end else begin
				finish = 1'b1;
			end
		end

		if (launch) begin
			if (ent_sel.present) begin
				held_d = ent_sel.value;
				kind_d = ent_sel.kind;
				rs_d   = 1'b0;
				ph_d   = PH_SETUP;
				cnt_d  = DLY_SETUP;
			end else begin
				finish = 1'b1;
			end
		end

		if (finish) begin
			ph_d   = PH_IDLE;
			init_d = 1'b0;
			cnt_d  = '0;
			done_d = 1'b1;
		end
	end

	// state and result share the same flops: hold them while the result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			held_q      <= '0;
			bus_q       <= '0;
			rs_q        <= 1'b0;
			en_q        <= 1'b0;
			mode_q      <= 1'b1;
			init_q      <= 1'b0;
			kind_q      <= KIND_BYTE;
			rej_q       <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				ph_q        <= ph_d;
				cnt_q       <= cnt_d;
				idx_q       <= idx_d;
				held_q      <= held_d;
				bus_q       <= bus_d;
				rs_q        <= rs_d;
				en_q        <= en_d;
				mode_q      <= mode_d;
				init_q      <= init_d;
				kind_q      <= kind_d;
				rej_q       <= rej_d;
				done_q      <= done_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res = '{
		rs:       rs_q,
		rw:       1'b0,
		en:       en_q,
		bus:      bus_q,
		busy:     (ph_q != PH_IDLE),
		rejected: rej_q,
		done:     done_q
	};

	`CLCD_ASSERT_IMP(a_done_idle, done_q, ph_q == PH_IDLE, "done pulse while sequence runs")
	`CLCD_ASSERT_IMP(a_en_busy, en_q, ph_q != PH_IDLE, "enable high while idle")
	`CLCD_ASSERT(a_idle_cnt, !(ph_q == PH_IDLE && cnt_q != '0), "idle with delay pending")
	`CLCD_ASSERT_IMP(a_rej_busy, rej_q && $past(take), $past(ph_q) != PH_IDLE, "reject while idle")

endmodule
`default_nettype wire

// ===== design/char_lcd_write_sequencer.sv =====
// Character LCD write sequencer top level: interface-mode register, input register, pin sequencer.
// Depends on clcd_pkg, clcd_in_reg and clcd_seq.
//
// Usage: every input word is one microsecond tick. command 0 only advances time;
// 1 writes an instruction, 2 writes a character, 3 sets the cursor from row and
// column, 4 runs the power-up init list. Each accepted word yields exactly one
// output word carrying the pin levels after that tick (rs_pin, rw_pin,
// enable_pin, data_bus) plus busy_res, request_rejected and sequence_done.
// Requests that arrive while a sequence runs are dropped and flagged.
// cfg_write/cfg_data set interface_mode (0 = 8-bit bus, 1 = 4-bit nibbles); it is
// sampled when a request starts, so write it only while the block is idle.
// An accepted word passes the input register, then the state/result register, on its way to the output.
// Throughput: one word per cycle while out_ready is high, set by the single-step next-state logic
// between the input register and the state/result register.
// A stalled output (out_ready low) freezes the sequencer; one more word waits in
// the input register, then in_ready drops. Reset clears all pins and state,
// sets 4-bit mode, and no clearing pass is needed.
`default_nettype none
module char_lcd_write_sequencer (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [2:0] command,
	input  wire  [7:0] byte_value,
	input  wire        row,
	input  wire  [5:0] column,
	output logic       out_valid,
	input  wire        out_ready,
	output logic       rs_pin,
	output logic       rw_pin,
	output logic       enable_pin,
	output logic [7:0] data_bus,
	output logic       busy_res,
	output logic       request_rejected,
	output logic       sequence_done,
	input  wire        cfg_write,
	input  wire        cfg_data
);
	import clcd_pkg::*;

	logic    mode_q;
	logic    take, valid_s1;
	item_t   item_in, item_s1;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_write) begin
			mode_q <= cfg_data;
		end
	end

	assign item_in = '{command: command, byte_value: byte_value, row: row, column: column};

	clcd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item_in),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	clcd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.cfg_mode  (mode_q),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign rs_pin           = res.rs;
	assign rw_pin           = res.rw;
	assign enable_pin       = res.en;
	assign data_bus         = res.bus;
	assign busy_res         = res.busy;
	assign request_rejected = res.rejected;
	assign sequence_done    = res.done;

endmodule
`default_nettype wire
